FILE: rtl/core/ptc_pkg.sv
// Shared types and constants for the pressure/temperature compensation block.
// Used by the register file, the controller, the datapath and the top level.
// No dependencies.
package ptc_pkg;

   // Field widths
   localparam int RAW_W   = 24;
   localparam int COEF_W  = 16;
   localparam int RES_OUT_W = 23;
   localparam int CSR_AW  = 5;
   localparam int CSR_DW  = 32;

   // Internal datapath widths
   localparam int DT_W    = 25;   // temperature difference, signed
   localparam int MB_W    = 18;   // multiplier B operand, signed
   localparam int PROD_W  = DT_W + MB_W;
   localparam int OFF_W   = 36;
   localparam int SENS_W  = 35;
   localparam int ACC_W   = 60;
   localparam int RES_W   = 41;

   // Scaling shifts (powers of two from the calibration formulas)
   localparam int TREF_SH     = 8;
   localparam int TEMPSENS_SH = 23;
   localparam int OFF_SH      = 17;
   localparam int TCO_SH      = 6;
   localparam int SENS_SH     = 16;
   localparam int TCS_SH      = 7;
   localparam int PRESS_SH    = 21;
   localparam int OUT_SH      = 15;
   localparam int SPLIT_SH    = 17;  // sens split for the narrow multiplier

   localparam logic signed [ACC_W-1:0] TEMP_BASE = 60'sd2000;
   localparam logic signed [RES_W-1:0] RES_MIN   = -41'sd4194304;
   localparam logic signed [RES_W-1:0] RES_MAX   = 41'sd4194303;

   // Register indexes
   localparam logic [2:0] REG_SENS     = 3'd0;
   localparam logic [2:0] REG_OFF      = 3'd1;
   localparam logic [2:0] REG_TCS      = 3'd2;
   localparam logic [2:0] REG_TCO      = 3'd3;
   localparam logic [2:0] REG_TREF     = 3'd4;
   localparam logic [2:0] REG_TEMPSENS = 3'd5;

   // Reading kinds
   localparam logic KIND_TEMP  = 1'b0;
   localparam logic KIND_PRESS = 1'b1;

   typedef struct packed {
      logic [COEF_W-1:0] sens;
      logic [COEF_W-1:0] off;
      logic [COEF_W-1:0] tcs;
      logic [COEF_W-1:0] tco;
      logic [COEF_W-1:0] tref;
      logic [COEF_W-1:0] tempsens;
   } coef_type;

   typedef enum logic [2:0] {
      MUL_TEMPSENS,
      MUL_TCO,
      MUL_TCS,
      MUL_RAW_LO,
      MUL_RAW_HI
   } mul_sel_type;

   typedef enum logic [2:0] {
      STEP_NONE,
      STEP_TEMP,
      STEP_OFF,
      STEP_SENS,
      STEP_ACC_LO,
      STEP_ACC_HI,
      STEP_SUB,
      STEP_SCALE
   } step_type;

   typedef struct packed {
      logic        load;
      logic        mul_en;
      mul_sel_type mul_sel;
      step_type    step;
      logic        out_load;
   } cmd_type;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_T_MUL,
      ST_T_SUM,
      ST_P_MUL_TCO,
      ST_P_OFF,
      ST_P_SENS,
      ST_P_MUL_LO,
      ST_P_MUL_HI,
      ST_P_ACC,
      ST_P_SUB,
      ST_P_SCALE,
      ST_DONE
   } state_type;

   // Signed divide by 2**k, truncating toward zero
   function automatic logic signed [ACC_W-1:0] trunc_shift(
      input logic signed [ACC_W-1:0] x,
      input int unsigned             k
   );
      logic signed [ACC_W-1:0] bias;
      bias = x[ACC_W-1] ? ((60'sd1 <<< k) - 60'sd1) : '0;
      return (x + bias) >>> k;
   endfunction

endpackage

FILE: rtl/core/ptc_csr.sv
// Calibration coefficient registers behind the APB-style configuration port.
// Depends on ptc_pkg.
module ptc_csr (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        csr_psel,
   input  logic                        csr_penable,
   input  logic                        csr_pwrite,
   input  logic [ptc_pkg::CSR_AW-1:0]  csr_paddr,
   input  logic [ptc_pkg::CSR_DW-1:0]  csr_pwdata,
   output logic [ptc_pkg::CSR_DW-1:0]  csr_prdata,
   output logic                        csr_pready,
   output ptc_pkg::coef_type           coef
);

   ptc_pkg::coef_type coef_ff, coef_in;
   logic [2:0]        reg_idx;
   logic              wr_en;

   assign reg_idx    = csr_paddr[4:2];
   assign wr_en      = csr_psel & csr_penable & csr_pwrite;
   assign csr_pready = 1'b1;
   assign coef       = coef_ff;

   // Write decode
   always_comb begin
      coef_in = coef_ff;
      if (wr_en) begin
         unique case (reg_idx)
            ptc_pkg::REG_SENS:     coef_in.sens     = csr_pwdata[15:0];
            ptc_pkg::REG_OFF:      coef_in.off      = csr_pwdata[15:0];
            ptc_pkg::REG_TCS:      coef_in.tcs      = csr_pwdata[15:0];
            ptc_pkg::REG_TCO:      coef_in.tco      = csr_pwdata[15:0];
            ptc_pkg::REG_TREF:     coef_in.tref     = csr_pwdata[15:0];
            ptc_pkg::REG_TEMPSENS: coef_in.tempsens = csr_pwdata[15:0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         coef_ff <= '0;
      end else begin
         coef_ff <= coef_in;
      end
   end

   // Read decode
   always_comb begin
      unique case (reg_idx)
         ptc_pkg::REG_SENS:     csr_prdata = {16'h0, coef_ff.sens};
         ptc_pkg::REG_OFF:      csr_prdata = {16'h0, coef_ff.off};
         ptc_pkg::REG_TCS:      csr_prdata = {16'h0, coef_ff.tcs};
         ptc_pkg::REG_TCO:      csr_prdata = {16'h0, coef_ff.tco};
         ptc_pkg::REG_TREF:     csr_prdata = {16'h0, coef_ff.tref};
         ptc_pkg::REG_TEMPSENS: csr_prdata = {16'h0, coef_ff.tempsens};
         default:               csr_prdata = '0;
      endcase
   end

endmodule

FILE: rtl/core/ptc_dp.sv
// Compensation datapath: one shared 25x18 signed multiplier, working registers,
// kept temperature difference and the result register. Depends on ptc_pkg.
module ptc_dp (
   input  logic                            clock,
   input  logic                            reset,
   input  ptc_pkg::cmd_type                cmd,
   input  ptc_pkg::coef_type               coef,
   input  logic                            in_kind,
   input  logic [ptc_pkg::RAW_W-1:0]       in_raw,
   output logic                            out_kind,
   output logic [ptc_pkg::RES_OUT_W-1:0]   out_value
);

   logic [ptc_pkg::RAW_W-1:0]               raw_ff, raw_in;
   logic                                    kind_ff, kind_in;
   logic signed [ptc_pkg::DT_W-1:0]         dt_ff, dt_in;
   logic signed [ptc_pkg::PROD_W-1:0]       prod_ff, prod_in;
   logic signed [ptc_pkg::OFF_W-1:0]        off_ff, off_in;
   logic signed [ptc_pkg::SENS_W-1:0]       sens_ff, sens_in;
   logic signed [ptc_pkg::ACC_W-1:0]        acc_ff, acc_in;
   logic signed [ptc_pkg::RES_W-1:0]        res_ff, res_in;
   logic                                    okind_ff, okind_in;
   logic [ptc_pkg::RES_OUT_W-1:0]           oval_ff, oval_in;

   logic [ptc_pkg::DT_W:0]                  dt_calc;
   logic signed [ptc_pkg::DT_W-1:0]         mul_a;
   logic signed [ptc_pkg::MB_W-1:0]         mul_b;
   logic signed [ptc_pkg::ACC_W-1:0]        prod_x;
   logic signed [ptc_pkg::ACC_W-1:0]        wide_t;
   logic signed [ptc_pkg::ACC_W-1:0]        base_t;
   logic signed [ptc_pkg::RES_W-1:0]        clamped;

   // Difference to the reference reading, in range of 25 signed bits
   assign dt_calc = {2'b00, in_raw} - {2'b00, coef.tref, 8'h00};
   assign prod_x  = ptc_pkg::ACC_W'(prod_ff);

   // Shared multiplier operand select
   always_comb begin
      mul_a = $signed({1'b0, raw_ff});
      mul_b = '0;
      case (cmd.mul_sel)
         ptc_pkg::MUL_TEMPSENS: begin
            mul_a = dt_ff;
            mul_b = $signed({2'b00, coef.tempsens});
         end
         ptc_pkg::MUL_TCO: begin
            mul_a = dt_ff;
            mul_b = $signed({2'b00, coef.tco});
         end
         ptc_pkg::MUL_TCS: begin
            mul_a = dt_ff;
            mul_b = $signed({2'b00, coef.tcs});
         end
         ptc_pkg::MUL_RAW_LO: mul_b = $signed({1'b0, sens_ff[16:0]});
         ptc_pkg::MUL_RAW_HI: mul_b = sens_ff[ptc_pkg::SENS_W-1:ptc_pkg::SPLIT_SH];
         default: ;
      endcase
   end

   assign prod_in = cmd.mul_en ? mul_a * mul_b : prod_ff;

   // Input capture and kept difference
   always_comb begin
      raw_in  = raw_ff;
      kind_in = kind_ff;
      dt_in   = dt_ff;
      if (cmd.load) begin
         raw_in  = in_raw;
         kind_in = in_kind;
         if (in_kind == ptc_pkg::KIND_TEMP) begin
            dt_in = $signed(dt_calc[ptc_pkg::DT_W-1:0]);
         end
      end
   end

   // Sequenced arithmetic steps
   always_comb begin
      off_in  = off_ff;
      sens_in = sens_ff;
      acc_in  = acc_ff;
      res_in  = res_ff;
      wide_t  = '0;
      base_t  = '0;
      case (cmd.step)
         ptc_pkg::STEP_TEMP: begin
            wide_t = ptc_pkg::trunc_shift(prod_x, ptc_pkg::TEMPSENS_SH);
            res_in = ptc_pkg::RES_W'(wide_t + ptc_pkg::TEMP_BASE);
         end
         ptc_pkg::STEP_OFF: begin
            base_t = $signed({44'h0, coef.off}) <<< ptc_pkg::OFF_SH;
            wide_t = ptc_pkg::trunc_shift(prod_x, ptc_pkg::TCO_SH);
            off_in = ptc_pkg::OFF_W'(base_t + wide_t);
         end
         ptc_pkg::STEP_SENS: begin
            base_t  = $signed({44'h0, coef.sens}) <<< ptc_pkg::SENS_SH;
            wide_t  = ptc_pkg::trunc_shift(prod_x, ptc_pkg::TCS_SH);
            sens_in = ptc_pkg::SENS_W'(base_t + wide_t);
         end
         ptc_pkg::STEP_ACC_LO: acc_in = prod_x;
         ptc_pkg::STEP_ACC_HI: acc_in = acc_ff + (prod_x <<< ptc_pkg::SPLIT_SH);
         ptc_pkg::STEP_SUB: begin
            wide_t = ptc_pkg::trunc_shift(acc_ff, ptc_pkg::PRESS_SH);
            res_in = ptc_pkg::RES_W'(wide_t - ptc_pkg::ACC_W'(off_ff));
         end
         ptc_pkg::STEP_SCALE: begin
            wide_t = ptc_pkg::trunc_shift(ptc_pkg::ACC_W'(res_ff), ptc_pkg::OUT_SH);
            res_in = ptc_pkg::RES_W'(wide_t);
         end
         default: ;
      endcase
   end

   // Saturate into the output field
   always_comb begin
      if (res_ff < ptc_pkg::RES_MIN) begin
         clamped = ptc_pkg::RES_MIN;
      end else if (res_ff > ptc_pkg::RES_MAX) begin
         clamped = ptc_pkg::RES_MAX;
      end else begin
         clamped = res_ff;
      end
   end

   assign okind_in = cmd.out_load ? kind_ff : okind_ff;
   assign oval_in  = cmd.out_load ? clamped[ptc_pkg::RES_OUT_W-1:0] : oval_ff;

   // Kept state
   always_ff @(posedge clock) begin
      if (reset) begin
         dt_ff <= '0;
      end else begin
         dt_ff <= dt_in;
      end
   end

   // Payload registers
   always_ff @(posedge clock) begin
      raw_ff   <= raw_in;
      kind_ff  <= kind_in;
      prod_ff  <= prod_in;
      off_ff   <= off_in;
      sens_ff  <= sens_in;
      acc_ff   <= acc_in;
      res_ff   <= res_in;
      okind_ff <= okind_in;
      oval_ff  <= oval_in;
   end

   assign out_kind  = okind_ff;
   assign out_value = oval_ff;

endmodule

FILE: rtl/core/ptc_ctrl.sv
// Sequencer for the compensation datapath and the result handshake.
// Depends on ptc_pkg.
module ptc_ctrl (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_tvalid,
   input  logic              req_kind,
   output logic              req_tready,
   output logic              rsp_tvalid,
   input  logic              rsp_tready,
   output ptc_pkg::cmd_type  cmd
);

   ptc_pkg::state_type state_ff, state_in;
   logic               rvalid_ff, rvalid_in;
   logic               out_free;

   assign out_free = ~rvalid_ff | rsp_tready;

   // Next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ptc_pkg::ST_IDLE: begin
            if (req_tvalid) begin
               state_in = (req_kind == ptc_pkg::KIND_PRESS) ? ptc_pkg::ST_P_MUL_TCO
                                                            : ptc_pkg::ST_T_MUL;
            end
         end
         ptc_pkg::ST_T_MUL:     state_in = ptc_pkg::ST_T_SUM;
         ptc_pkg::ST_T_SUM:     state_in = ptc_pkg::ST_DONE;
         ptc_pkg::ST_P_MUL_TCO: state_in = ptc_pkg::ST_P_OFF;
         ptc_pkg::ST_P_OFF:     state_in = ptc_pkg::ST_P_SENS;
         ptc_pkg::ST_P_SENS:    state_in = ptc_pkg::ST_P_MUL_LO;
         ptc_pkg::ST_P_MUL_LO:  state_in = ptc_pkg::ST_P_MUL_HI;
         ptc_pkg::ST_P_MUL_HI:  state_in = ptc_pkg::ST_P_ACC;
         ptc_pkg::ST_P_ACC:     state_in = ptc_pkg::ST_P_SUB;
         ptc_pkg::ST_P_SUB:     state_in = ptc_pkg::ST_P_SCALE;
         ptc_pkg::ST_P_SCALE:   state_in = ptc_pkg::ST_DONE;
         ptc_pkg::ST_DONE: begin
            if (out_free) begin
               state_in = ptc_pkg::ST_IDLE;
            end
         end
         default:               state_in = ptc_pkg::ST_IDLE;
      endcase
   end

   // Command outputs
   always_comb begin
      cmd         = '0;
      cmd.mul_sel = ptc_pkg::MUL_TEMPSENS;
      cmd.step    = ptc_pkg::STEP_NONE;
      req_tready  = 1'b0;
      unique case (state_ff)
         ptc_pkg::ST_IDLE: begin
            req_tready = 1'b1;
            cmd.load   = req_tvalid;
         end
         ptc_pkg::ST_T_MUL: begin
            cmd.mul_en  = 1'b1;
            cmd.mul_sel = ptc_pkg::MUL_TEMPSENS;
         end
         ptc_pkg::ST_T_SUM:     cmd.step = ptc_pkg::STEP_TEMP;
         ptc_pkg::ST_P_MUL_TCO: begin
            cmd.mul_en  = 1'b1;
            cmd.mul_sel = ptc_pkg::MUL_TCO;
         end
         ptc_pkg::ST_P_OFF: begin
            cmd.step    = ptc_pkg::STEP_OFF;
            cmd.mul_en  = 1'b1;
            cmd.mul_sel = ptc_pkg::MUL_TCS;
         end
         ptc_pkg::ST_P_SENS:    cmd.step = ptc_pkg::STEP_SENS;
         ptc_pkg::ST_P_MUL_LO: begin
            cmd.mul_en  = 1'b1;
            cmd.mul_sel = ptc_pkg::MUL_RAW_LO;
         end
         ptc_pkg::ST_P_MUL_HI: begin
            cmd.step    = ptc_pkg::STEP_ACC_LO;
            cmd.mul_en  = 1'b1;
            cmd.mul_sel = ptc_pkg::MUL_RAW_HI;
         end
         ptc_pkg::ST_P_ACC:     cmd.step = ptc_pkg::STEP_ACC_HI;
         ptc_pkg::ST_P_SUB:     cmd.step = ptc_pkg::STEP_SUB;
         ptc_pkg::ST_P_SCALE:   cmd.step = ptc_pkg::STEP_SCALE;
         ptc_pkg::ST_DONE:      cmd.out_load = out_free;
         default: ;
      endcase
   end

   // Result valid flag
   always_comb begin
      rvalid_in = rvalid_ff;
      if (rsp_tready) begin
         rvalid_in = 1'b0;
      end
      if (state_ff == ptc_pkg::ST_DONE && out_free) begin
         rvalid_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= ptc_pkg::ST_IDLE;
         rvalid_ff <= 1'b0;
      end else begin
         state_ff  <= state_in;
         rvalid_ff <= rvalid_in;
      end
   end

   assign rsp_tvalid = rvalid_ff;

endmodule

FILE: rtl/core/pressure_temp_compensation.sv
// Barometric sensor first-order compensation. Raw 24-bit readings enter on the
// req_ stream tagged by tuser (0 temperature, 1 pressure) and each produces one
// result on the rsp_ stream. Pressure takes longer than temperature from accept
// to the next ready because the sequencer uses the single shared 25x18
// multiplier once for temperature and four times for pressure (the 35-bit
// sensitivity is applied in two halves, low then high).
// A finished result sits in an output register, so the next reading is taken
// while it waits. The six coefficients are written through the csr_ port at
// byte addresses 0, 4, ..., 20 and must only change while the block is idle.
// Depends on ptc_pkg, ptc_csr, ptc_ctrl and ptc_dp.
module pressure_temp_compensation (
   input  logic                        clock,
   input  logic                        reset,
   // input stream
   input  logic                        req_tvalid,
   output logic                        req_tready,
   input  logic [23:0]                 req_tdata,   // [23:0] raw_value
   input  logic                        req_tuser,   // [0] action
   // result stream
   output logic                        rsp_tvalid,
   input  logic                        rsp_tready,
   output logic [23:0]                 rsp_tdata,   // [22:0] result_value, [23] zero
   output logic                        rsp_tuser,   // [0] kind
   // configuration port
   input  logic                        csr_psel,
   input  logic                        csr_penable,
   input  logic                        csr_pwrite,
   input  logic [ptc_pkg::CSR_AW-1:0]  csr_paddr,
   input  logic [ptc_pkg::CSR_DW-1:0]  csr_pwdata,
   output logic [ptc_pkg::CSR_DW-1:0]  csr_prdata,
   output logic                        csr_pready
);

   ptc_pkg::coef_type               coef;
   ptc_pkg::cmd_type                cmd;
   logic [ptc_pkg::RES_OUT_W-1:0]   result_value;

   ptc_csr u_csr (
      .clock       (clock),
      .reset       (reset),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready),
      .coef        (coef)
   );

   ptc_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_kind   (req_tuser),
      .req_tready (req_tready),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .cmd        (cmd)
   );

   ptc_dp u_dp (
      .clock     (clock),
      .reset     (reset),
      .cmd       (cmd),
      .coef      (coef),
      .in_kind   (req_tuser),
      .in_raw    (req_tdata),
      .out_kind  (rsp_tuser),
      .out_value (result_value)
   );

   assign rsp_tdata = {1'b0, result_value};

endmodule

FILE: tb/sv/pressure_temp_compensation_test.sv
`timescale 1ns / 1ps
// Self-checking testbench for pressure_temp_compensation: streams temperature and pressure
// readings under directed and random coefficient settings and checks every result.
// Depends on ptc_pkg and the pressure_temp_compensation top level.
module pressure_temp_compensation_test;

   localparam int     NUM_COEFS       = 6;
   localparam int     ITEMS_PER_PHASE = 258;
   localparam int     RAND_PHASES     = 6;
   localparam int     SETTLE_CYCLES   = 16;
   localparam int     LONG_HOLD       = 400;
   localparam longint TIMEOUT_NS      = 2_000_000;

   // Unused register slots past the coefficient list
   localparam logic [2:0] REG_UNUSED_LO = 3'd6;
   localparam logic [2:0] REG_UNUSED_HI = 3'd7;

   // Calibration scale factors
   localparam longint TEMP_OFFSET   = 2000;
   localparam longint TREF_SCALE    = 256;
   localparam longint TEMPSENS_DIV  = 8388608;
   localparam longint OFF_SCALE     = 131072;
   localparam longint TCO_DIV       = 64;
   localparam longint SENS_SCALE    = 65536;
   localparam longint TCS_DIV       = 128;
   localparam longint PRESS_DIV     = 2097152;
   localparam longint OUT_DIV       = 32768;
   localparam longint RESULT_LOW    = -4194304;
   localparam longint RESULT_HIGH   = 4194303;

   typedef struct packed {
      logic                          kind;
      logic [ptc_pkg::RES_OUT_W-1:0] value;
   } reading_result_type;

   // Tracks coefficients and the kept temperature difference, predicts each result
   class compensation_scoreboard;
      ptc_pkg::coef_type               coefs;
      logic signed [ptc_pkg::DT_W-1:0] temp_diff;
      reading_result_type              pending_results[$];
      int                              errors;
      int                              temp_checked;
      int                              press_checked;

      function new();
         coefs = '0;
         temp_diff = '0;
         errors = 0;
         temp_checked = 0;
         press_checked = 0;
      endfunction

      task report_mismatch(input string what);
         $display("MISMATCH @%0t: %s", $time, what);
         errors++;
      endtask

      function void set_coef(input logic [2:0] idx, input logic [ptc_pkg::COEF_W-1:0] val);
         case (idx)
            ptc_pkg::REG_SENS:     coefs.sens = val;
            ptc_pkg::REG_OFF:      coefs.off = val;
            ptc_pkg::REG_TCS:      coefs.tcs = val;
            ptc_pkg::REG_TCO:      coefs.tco = val;
            ptc_pkg::REG_TREF:     coefs.tref = val;
            ptc_pkg::REG_TEMPSENS: coefs.tempsens = val;
            default: ;
         endcase
      endfunction

      function logic [ptc_pkg::COEF_W-1:0] get_coef(input logic [2:0] idx);
         case (idx)
            ptc_pkg::REG_SENS:     return coefs.sens;
            ptc_pkg::REG_OFF:      return coefs.off;
            ptc_pkg::REG_TCS:      return coefs.tcs;
            ptc_pkg::REG_TCO:      return coefs.tco;
            ptc_pkg::REG_TREF:     return coefs.tref;
            ptc_pkg::REG_TEMPSENS: return coefs.tempsens;
            default:               return '0;
         endcase
      endfunction

      function int pending();
         return pending_results.size();
      endfunction

      // Accepted reading: compute the compensated value and queue it
      function void note_reading(input logic action, input logic [ptc_pkg::RAW_W-1:0] raw);
         longint diff, offset, gain, res;
         reading_result_type r;
         if (action == ptc_pkg::KIND_TEMP) begin
            diff = longint'(raw) - longint'(coefs.tref) * TREF_SCALE;
            temp_diff = diff[ptc_pkg::DT_W-1:0];
            res = TEMP_OFFSET + (diff * longint'(coefs.tempsens)) / TEMPSENS_DIV;
         end else begin
            diff = longint'(temp_diff);
            offset = longint'(coefs.off) * OFF_SCALE + (diff * longint'(coefs.tco)) / TCO_DIV;
            gain = longint'(coefs.sens) * SENS_SCALE + (diff * longint'(coefs.tcs)) / TCS_DIV;
            res = ((longint'(raw) * gain) / PRESS_DIV - offset) / OUT_DIV;
         end
         // saturate to the signed output range
         if (res < RESULT_LOW) res = RESULT_LOW;
         if (res > RESULT_HIGH) res = RESULT_HIGH;
         r.kind = action;
         r.value = res[ptc_pkg::RES_OUT_W-1:0];
         pending_results.push_back(r);
      endfunction

      // Accepted result: compare against the oldest prediction
      task check_result(input logic kind, input logic [ptc_pkg::RES_OUT_W-1:0] value);
         reading_result_type want;
         if (pending_results.size() == 0) begin
            report_mismatch($sformatf("unexpected result kind %0d value %0d",
                                      kind, $signed(value)));
            return;
         end
         want = pending_results.pop_front();
         if (kind !== want.kind)
            report_mismatch($sformatf("kind %0d, expected %0d", kind, want.kind));
         if (value !== want.value)
            report_mismatch($sformatf("kind %0d value %0d, expected %0d",
                                      want.kind, $signed(value), $signed(want.value)));
         if (want.kind == ptc_pkg::KIND_TEMP)
            temp_checked++;
         else
            press_checked++;
      endtask
   endclass

   logic                         clock = 1'b0;
   logic                         reset = 1'b1;
   logic                         req_tvalid = 1'b0;
   logic                         req_tready;
   logic [23:0]                  req_tdata = '0;    // [23:0] raw_value
   logic                         req_tuser = 1'b0;  // [0] action
   logic                         rsp_tvalid;
   logic                         rsp_tready = 1'b0;
   logic [23:0]                  rsp_tdata;         // [22:0] result_value, [23] zero
   logic                         rsp_tuser;         // [0] kind
   logic                         csr_psel = 1'b0;
   logic                         csr_penable = 1'b0;
   logic                         csr_pwrite = 1'b0;
   logic [ptc_pkg::CSR_AW-1:0]   csr_paddr = '0;
   logic [ptc_pkg::CSR_DW-1:0]   csr_pwdata = '0;
   logic [ptc_pkg::CSR_DW-1:0]   csr_prdata;
   logic                         csr_pready;

   compensation_scoreboard comp_sb;
   bit                  quiet = 1'b0;
   bit                  hold_trigger = 1'b0;
   bit                  drain_hold = 1'b0;
   int                  hold_seen = 0;
   int                  setting_count = 0;
   int                  readback_count = 0;

   pressure_temp_compensation u_dut (
      .clock       (clock),
      .reset       (reset),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tdata   (req_tdata),
      .req_tuser   (req_tuser),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),
      .rsp_tuser   (rsp_tuser),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready)
   );

   always #2 clock = ~clock;

   // APB write: setup then access; the scoreboard follows the written value
   task automatic csr_write(input logic [ptc_pkg::CSR_AW-1:0] addr,
                            input logic [ptc_pkg::CSR_DW-1:0] data);
      @(posedge clock);
      csr_psel <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite <= 1'b1;
      csr_paddr <= addr;
      csr_pwdata <= data;
      @(posedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (!csr_pready);
      csr_psel <= 1'b0;
      csr_penable <= 1'b0;
      comp_sb.set_coef(addr[ptc_pkg::CSR_AW-1:2], data[ptc_pkg::COEF_W-1:0]);
   endtask

   // Write one coefficient with junk in the upper bits, then read it back
   task automatic csr_set(input logic [2:0] idx, input logic [ptc_pkg::COEF_W-1:0] val);
      logic [ptc_pkg::CSR_DW-1:0] wdata, rdata;
      wdata = $urandom;
      wdata[ptc_pkg::COEF_W-1:0] = val;
      csr_write({idx, 2'b00}, wdata);
      @(posedge clock);
      csr_psel <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite <= 1'b0;
      csr_paddr <= {idx, 2'b00};
      @(posedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (!csr_pready);
      rdata = csr_prdata;
      csr_psel <= 1'b0;
      csr_penable <= 1'b0;
      readback_count++;
      if (rdata !== {{(ptc_pkg::CSR_DW-ptc_pkg::COEF_W){1'b0}}, comp_sb.get_coef(idx)})
         comp_sb.report_mismatch($sformatf("register %0d reads %h, written %h",
                                           idx, rdata, wdata));
   endtask

   task automatic load_coefs(input ptc_pkg::coef_type c);
      csr_set(ptc_pkg::REG_SENS, c.sens);
      csr_set(ptc_pkg::REG_OFF, c.off);
      csr_set(ptc_pkg::REG_TCS, c.tcs);
      csr_set(ptc_pkg::REG_TCO, c.tco);
      csr_set(ptc_pkg::REG_TREF, c.tref);
      csr_set(ptc_pkg::REG_TEMPSENS, c.tempsens);
      setting_count++;
   endtask

   function automatic ptc_pkg::coef_type random_coefs(input bit with_extremes);
      ptc_pkg::coef_type c;
      logic [ptc_pkg::COEF_W-1:0] v;
      for (int i = 0; i < NUM_COEFS; i++) begin
         case (with_extremes ? $urandom_range(0, 2) : 2)
            0:       v = '0;
            1:       v = '1;
            default: v = ptc_pkg::COEF_W'($urandom);
         endcase
         c[i*ptc_pkg::COEF_W +: ptc_pkg::COEF_W] = v;
      end
      return c;
   endfunction

   // Raw value: extremes, near the reference reading, or anything
   function automatic logic [ptc_pkg::RAW_W-1:0] pick_raw(input bit near_ref);
      int v;
      case ($urandom_range(0, 9))
         0: return '0;
         1: return '1;
         2, 3, 4: if (near_ref) begin
            v = int'(comp_sb.coefs.tref) * 256 + int'($urandom_range(0, 4095)) - 2048;
            if (v < 0) v = 0;
            if (v > 24'hFF_FFFF) v = 24'hFF_FFFF;
            return v[ptc_pkg::RAW_W-1:0];
         end
         default: ;
      endcase
      return ptc_pkg::RAW_W'($urandom);
   endfunction

   // Offer one reading after a random gap (none while quiet); valid stays up into the next call
   task automatic send_reading(input logic action, input logic [ptc_pkg::RAW_W-1:0] raw);
      int gap;
      gap = quiet ? 0 : $urandom_range(0, 11);
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata <= raw;
      req_tuser <= action;
      do @(posedge clock); while (!req_tready);
      comp_sb.note_reading(action, raw);
   endtask

   // Drop valid and let all results drain before touching registers
   task automatic wait_idle();
      req_tvalid <= 1'b0;
      while (comp_sb.pending() > 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   // Result sink with random stalls and one long hold-off
   initial begin : result_drain
      int stall;
      do @(posedge clock); while (reset);
      forever begin
         stall = quiet ? 0 : $urandom_range(0, 11);
         if (stall > 0 || drain_hold) begin
            rsp_tready <= 1'b0;
            repeat (stall) @(posedge clock);
            while (drain_hold) @(posedge clock);
         end
         rsp_tready <= 1'b1;
         do @(posedge clock); while (!rsp_tvalid);
         comp_sb.check_result(rsp_tuser, rsp_tdata[ptc_pkg::RES_OUT_W-1:0]);
      end
   end

   // Long receiver hold-off, counted here while the sender keeps offering
   initial begin : long_hold
      wait (hold_trigger);
      drain_hold = 1'b1;
      repeat (LONG_HOLD) begin
         @(posedge clock);
         hold_seen++;
      end
      drain_hold = 1'b0;
   end

   initial begin : run_timeout
      #(TIMEOUT_NS);
      $display("RESULT: ERROR");
      $finish;
   end

   initial begin : stimulus
      ptc_pkg::coef_type setting;
      int                sent, extra;
      comp_sb = new();
      repeat (8) @(posedge clock);
      reset <= 1'b0;
      wait_idle();

      // Directed: typical coefficients, pressure before any temperature
      setting = '{sens: 16'd46372, off: 16'd43981, tcs: 16'd29059, tco: 16'd27842,
                  tref: 16'd31553, tempsens: 16'd28165};
      load_coefs(setting);
      send_reading(ptc_pkg::KIND_PRESS, 24'h4E8A2C);
      send_reading(ptc_pkg::KIND_PRESS, 24'h000000);
      send_reading(ptc_pkg::KIND_PRESS, 24'hFFFFFF);
      send_reading(ptc_pkg::KIND_TEMP, {setting.tref, 8'h00});
      send_reading(ptc_pkg::KIND_TEMP, 24'h000000);
      send_reading(ptc_pkg::KIND_PRESS, 24'hFFFFFF);
      send_reading(ptc_pkg::KIND_PRESS, 24'h000000);
      send_reading(ptc_pkg::KIND_TEMP, 24'hFFFFFF);
      send_reading(ptc_pkg::KIND_PRESS, 24'h8A3B5C);
      send_reading(ptc_pkg::KIND_PRESS, 24'hFFFFFF);
      wait_idle();

      // All coefficients at maximum; writes past the register list must not alias
      load_coefs('1);
      csr_write({REG_UNUSED_LO, 2'b00}, '0);
      csr_write({REG_UNUSED_HI, 2'b00}, '0);
      send_reading(ptc_pkg::KIND_TEMP, 24'h000000);
      send_reading(ptc_pkg::KIND_PRESS, 24'hFFFFFF);
      send_reading(ptc_pkg::KIND_PRESS, 24'h000000);
      send_reading(ptc_pkg::KIND_TEMP, 24'hFFFFFF);
      send_reading(ptc_pkg::KIND_PRESS, 24'hFFFFFF);
      wait_idle();

      // Zero reference: largest positive temperature difference
      setting = '1;
      setting.tref = '0;
      load_coefs(setting);
      send_reading(ptc_pkg::KIND_TEMP, 24'hFFFFFF);
      send_reading(ptc_pkg::KIND_PRESS, 24'hFFFFFF);
      send_reading(ptc_pkg::KIND_PRESS, 24'h000000);
      send_reading(ptc_pkg::KIND_TEMP, 24'h000000);
      send_reading(ptc_pkg::KIND_PRESS, 24'hFFFFFF);

      // Random phases, each under its own coefficient setting
      for (int phase = 0; phase < RAND_PHASES; phase++) begin
         wait_idle();
         case (phase)
            1:       setting = '1;
            2:       setting = '0;
            3, 5:    setting = random_coefs(1'b1);
            default: setting = random_coefs(1'b0);
         endcase
         load_coefs(setting);
         sent = 0;
         while (sent < ITEMS_PER_PHASE) begin
            quiet = ((sent / 64) % 4 == 2);
            if (phase == 1 && sent >= 30)
               hold_trigger = 1'b1;
            if ($urandom_range(0, 9) < 8) begin
               // usual order: one temperature, then one to three pressures
               extra = $urandom_range(1, 3);
               send_reading(ptc_pkg::KIND_TEMP, pick_raw(1'b1));
               repeat (extra) send_reading(ptc_pkg::KIND_PRESS, pick_raw(1'b0));
               sent += 1 + extra;
            end else begin
               send_reading(1'($urandom_range(0, 1)), pick_raw(1'($urandom_range(0, 1))));
               sent++;
            end
         end
      end
      quiet = 1'b0;
      wait_idle();

      $display("Checked %0d temperature and %0d pressure results over %0d coefficient settings,",
               comp_sb.temp_checked, comp_sb.press_checked, setting_count);
      $display("with %0d register readbacks and a %0d-cycle result hold-off.",
               readback_count, hold_seen);
      if (comp_sb.errors == 0 && comp_sb.pending() == 0)
         $display("RESULT: OK");
      else
         $display("RESULT: ERROR");
      $finish;
   end

endmodule

FILE: filelist.f
rtl/core/ptc_pkg.sv
rtl/core/ptc_csr.sv
rtl/core/ptc_dp.sv
rtl/core/ptc_ctrl.sv
rtl/core/pressure_temp_compensation.sv
tb/sv/pressure_temp_compensation_test.sv
